// ===== rtl/ngsm_pkg.sv =====
// shared types, character constants and lookup functions for the nmea gga speed merger
package ngsm_pkg;

	// line classification, one-hot
	typedef enum logic [3:0] {
		KIND_UNDEC = 4'b0001,
		KIND_GGA   = 4'b0010,
		KIND_RMC   = 4'b0100,
		KIND_OTHER = 4'b1000
	} line_kind_t;

	// work items handed from the classifier to the output sequencer
	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_TAG,
		CMD_SPEED,
		CMD_NOVEL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
	} cmd_t;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	localparam int TAG_LEN   = 6;
	localparam int NOVEL_LEN = 9;

	// letters, digits, newline, comma, dollar and dot survive the filter
	function automatic logic is_kept(input logic [7:0] c);
		logic r;
		r = 1'b0;
		if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
		if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
		if (c == CH_NL || c == CH_COMMA || c == CH_DOLLAR || c == CH_DOT) r = 1'b1;
		return r;
	endfunction

	// "$GPGGA"
	function automatic logic [7:0] gga_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h24;
			3'd1:    r = 8'h47;
			3'd2:    r = 8'h50;
			3'd3:    r = 8'h47;
			3'd4:    r = 8'h47;
			default: r = 8'h41;
		endcase
		return r;
	endfunction

	// "$GPRMC"
	function automatic logic [7:0] rmc_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h24;
			3'd1:    r = 8'h47;
			3'd2:    r = 8'h50;
			3'd3:    r = 8'h52;
			3'd4:    r = 8'h4D;
			default: r = 8'h43;
		endcase
		return r;
	endfunction

	// ",NoNewVel"
	function automatic logic [7:0] novel_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h2C;
			4'd1:    r = 8'h4E;
			4'd2:    r = 8'h6F;
			4'd3:    r = 8'h4E;
			4'd4:    r = 8'h65;
			4'd5:    r = 8'h77;
			4'd6:    r = 8'h56;
			4'd7:    r = 8'h65;
			default: r = 8'h6C;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/ngsm_front.sv =====
// front end: byte filter, line classifier, rmc token tracker and speed store
module ngsm_front #(
	parameter int VEL_MAX = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_char,
	input  logic [3:0]                   speed_idx,
	output logic                         push,
	output ngsm_pkg::cmd_t               push_cmd,
	input  logic                         q_full,
	input  logic                         tail_done,
	output logic [VEL_MAX-1:0][7:0]      speed_data,
	output logic [$clog2(VEL_MAX+1)-1:0] speed_len
);

	localparam int LW      = $clog2(VEL_MAX + 1);
	localparam int PRE_LEN = (VEL_MAX < ngsm_pkg::TAG_LEN) ? VEL_MAX : ngsm_pkg::TAG_LEN;

	ngsm_pkg::line_kind_t kind_q, kind_d;
	logic [2:0]           kept_q, kept_d;
	logic                 gga_ok_q, gga_ok_d;
	logic                 rmc_ok_q, rmc_ok_d;
	logic [3:0]           tok_q, tok_d;
	logic                 inside_q, inside_d;
	logic [LW-1:0]        len_q, len_d;
	logic                 fresh_q, fresh_d;
	logic                 hold_q, hold_d;
	logic [VEL_MAX-1:0][7:0] store_q;

	logic acc;
	logic ok_g, ok_r;
	logic app_wr, pre_wr;
	logic room;

	// input is held while the queue is full or a sentence tail reads the speed store
	assign in_ready   = !q_full && !hold_q;
	assign acc        = in_valid && in_ready && ngsm_pkg::is_kept(in_char);
	assign room       = (len_q < LW'(VEL_MAX));
	assign ok_g       = gga_ok_q && (in_char == ngsm_pkg::gga_char(kept_q));
	assign ok_r       = rmc_ok_q && (in_char == ngsm_pkg::rmc_char(kept_q));
	assign speed_data = store_q;
	assign speed_len  = len_q;

	// next line state and work items
	always_comb begin
		kind_d   = kind_q;
		kept_d   = kept_q;
		gga_ok_d = gga_ok_q;
		rmc_ok_d = rmc_ok_q;
		tok_d    = tok_q;
		inside_d = inside_q;
		len_d    = len_q;
		fresh_d  = fresh_q;
		hold_d   = hold_q && !tail_done;
		push     = 1'b0;
		push_cmd = '{kind: ngsm_pkg::CMD_CHAR, ch: in_char};
		app_wr   = 1'b0;
		pre_wr   = 1'b0;
		if (acc) begin
			if (in_char == ngsm_pkg::CH_NL) begin
				if (kind_q == ngsm_pkg::KIND_GGA) begin
					push          = 1'b1;
					push_cmd.kind = fresh_q ? ngsm_pkg::CMD_SPEED : ngsm_pkg::CMD_NOVEL;
					fresh_d       = 1'b0;
					hold_d        = 1'b1;
				end else if (kind_q == ngsm_pkg::KIND_RMC) begin
					fresh_d = 1'b1;
				end
				kind_d   = ngsm_pkg::KIND_UNDEC;
				kept_d   = '0;
				gga_ok_d = 1'b1;
				rmc_ok_d = 1'b1;
				tok_d    = '0;
				inside_d = 1'b0;
			end else begin
				unique case (kind_q)
					ngsm_pkg::KIND_UNDEC: begin
						kept_d   = kept_q + 3'd1;
						gga_ok_d = ok_g;
						rmc_ok_d = ok_r;
						if (kept_q == 3'(ngsm_pkg::TAG_LEN - 1)) begin
							if (ok_g) begin
								kind_d        = ngsm_pkg::KIND_GGA;
								push          = 1'b1;
								push_cmd.kind = ngsm_pkg::CMD_TAG;
							end else if (ok_r) begin
								kind_d   = ngsm_pkg::KIND_RMC;
								tok_d    = '0;
								inside_d = 1'b1;
								if (speed_idx == 4'd0) begin
									pre_wr = 1'b1;
									len_d  = LW'(PRE_LEN);
								end else begin
									len_d = '0;
								end
							end else begin
								kind_d = ngsm_pkg::KIND_OTHER;
							end
						end
					end
					ngsm_pkg::KIND_GGA: begin
						push = 1'b1;
					end
					ngsm_pkg::KIND_RMC: begin
						if (in_char == ngsm_pkg::CH_COMMA) begin
							inside_d = 1'b0;
						end else begin
							if (!inside_q && tok_q != 4'd15) begin
								tok_d    = tok_q + 4'd1;
								inside_d = 1'b1;
							end
							if (inside_d && tok_d == speed_idx && room) begin
								app_wr = 1'b1;
								len_d  = len_q + LW'(1);
							end
						end
					end
					ngsm_pkg::KIND_OTHER: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= ngsm_pkg::KIND_UNDEC;
			kept_q   <= '0;
			gga_ok_q <= 1'b1;
			rmc_ok_q <= 1'b1;
			tok_q    <= '0;
			inside_q <= 1'b0;
			len_q    <= '0;
			fresh_q  <= 1'b0;
			hold_q   <= 1'b0;
		end else begin
			kind_q   <= kind_d;
			kept_q   <= kept_d;
			gga_ok_q <= gga_ok_d;
			rmc_ok_q <= rmc_ok_d;
			tok_q    <= tok_d;
			inside_q <= inside_d;
			len_q    <= len_d;
			fresh_q  <= fresh_d;
			hold_q   <= hold_d;
		end
	end

	// speed characters, tag copy when the tag token itself is selected
	always_ff @(posedge clk) begin
		for (int i = 0; i < VEL_MAX; i++) begin
			if (pre_wr && i < ngsm_pkg::TAG_LEN) begin
				store_q[i] <= ngsm_pkg::rmc_char(3'(i));
			end else if (app_wr && len_q == LW'(i)) begin
				store_q[i] <= in_char;
			end
		end
	end

endmodule

// ===== rtl/ngsm_queue.sv =====
// two-entry work queue between classifier and output sequencer
module ngsm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ngsm_pkg::cmd_t wdata,
	output logic           full,
	output logic           valid,
	output ngsm_pkg::cmd_t rdata,
	input  logic           pop
);

	ngsm_pkg::cmd_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== rtl/ngsm_back.sv =====
// back end: expands work items into output bytes through an output register
module ngsm_back #(
	parameter int VEL_MAX = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  ngsm_pkg::cmd_t               q_cmd,
	output logic                         q_pop,
	output logic                         tail_done,
	input  logic [VEL_MAX-1:0][7:0]      speed_data,
	input  logic [$clog2(VEL_MAX+1)-1:0] speed_len,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_char,
	output logic                         out_last,
	output logic                         out_eos
);

	localparam int TAIL_MAX = (VEL_MAX + 1 > ngsm_pkg::NOVEL_LEN) ? VEL_MAX + 1
	                                                              : ngsm_pkg::NOVEL_LEN;
	localparam int CW = $clog2(TAIL_MAX + 1);
	localparam int AW = (VEL_MAX > 1) ? $clog2(VEL_MAX) : 1;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] rd_idx;
	logic          load;
	logic [7:0]    b_char;
	logic          b_last, b_eos;
	logic          valid_q;
	logic [7:0]    char_q;
	logic          last_q, eos_q;

	assign cnt_m1 = cnt_q - CW'(1);
	assign rd_idx = cnt_m1[AW-1:0];

	// byte selection for the head item
	always_comb begin
		b_char = q_cmd.ch;
		b_last = 1'b1;
		b_eos  = 1'b0;
		case (q_cmd.kind)
			ngsm_pkg::CMD_TAG: begin
				b_char = ngsm_pkg::gga_char(cnt_q[2:0]);
				b_last = (cnt_q == CW'(ngsm_pkg::TAG_LEN - 1));
			end
			ngsm_pkg::CMD_SPEED: begin
				b_last = 1'b0;
				if (cnt_q == '0) begin
					b_char = ngsm_pkg::CH_COMMA;
				end else if (cnt_q == CW'(speed_len) + CW'(1)) begin
					b_char = ngsm_pkg::CH_NL;
					b_last = 1'b1;
					b_eos  = 1'b1;
				end else begin
					b_char = speed_data[rd_idx];
				end
			end
			ngsm_pkg::CMD_NOVEL: begin
				b_last = 1'b0;
				if (cnt_q == CW'(ngsm_pkg::NOVEL_LEN)) begin
					b_char = ngsm_pkg::CH_NL;
					b_last = 1'b1;
					b_eos  = 1'b1;
				end else begin
					b_char = ngsm_pkg::novel_char(cnt_q[3:0]);
				end
			end
			default: begin
			end
		endcase
	end

	assign load      = q_valid && (!valid_q || out_ready);
	assign q_pop     = load && b_last;
	assign tail_done = q_pop && (q_cmd.kind == ngsm_pkg::CMD_SPEED ||
	                             q_cmd.kind == ngsm_pkg::CMD_NOVEL);

	// byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) cnt_q <= b_last ? '0 : cnt_q + CW'(1);
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b_char;
			last_q <= b_last;
			eos_q  <= b_eos;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_eos   = eos_q;

endmodule

// ===== rtl/nmea_gga_speed_merger.sv =====
// Merges the speed of $GPRMC sentences into the $GPGGA sentences of a raw NMEA byte stream.
// Input bytes are filtered and classified at one byte per cycle; a two-entry queue
// decouples that from the output sequencer, which emits one byte per cycle while the output
// is ready, through an output register. A byte in a GGA line yields one output byte, the
// GGA tag six, and the sentence end speed_len + 2 (speed appended) or 10 (",NoNewVel" appended).
// Input stalls while the queue is full, and after a GGA newline transfer it is held until
// the closing newline of that tail is loaded into the output register, because the tail
// reads the speed store. cfg_data sets the index of the non-empty RMC token that carries
// the speed (reset 7); write it only while the block is idle.
module nmea_gga_speed_merger #(
	parameter int VEL_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_char
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast,  // end_of_run
	output logic       m_axis_tuser,  // [0] end_of_sentence
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data       // speed_field_index
);

	localparam int LW = $clog2(VEL_MAX + 1);

	logic [3:0]              speed_idx_q;
	logic                    push, q_full, q_valid, q_pop, tail_done;
	ngsm_pkg::cmd_t          push_cmd, q_cmd;
	logic [VEL_MAX-1:0][7:0] speed_data;
	logic [LW-1:0]           speed_len;

	// speed token index register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_idx_q <= 4'd7;
		end else if (cfg_valid && cfg_ready) begin
			speed_idx_q <= cfg_data;
		end
	end

	ngsm_front #(.VEL_MAX(VEL_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_char    (s_axis_tdata),
		.speed_idx  (speed_idx_q),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full),
		.tail_done  (tail_done),
		.speed_data (speed_data),
		.speed_len  (speed_len)
	);

	ngsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_cmd),
		.pop    (q_pop)
	);

	ngsm_back #(.VEL_MAX(VEL_MAX)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.tail_done  (tail_done),
		.speed_data (speed_data),
		.speed_len  (speed_len),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_eos    (m_axis_tuser)
	);

endmodule

// ===== rtl/ngsm_checker.sv =====
// port-level checks for the nmea gga speed merger, bound to the top level
module ngsm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// a stalled output stays valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	// a stalled output keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	// sentence end is always a newline closing its run
	a_eos_newline: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h0A)
		else $error("end of sentence not on a closing newline");

	// a run continues without a gap once started
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside an output run");

endmodule

bind nmea_gga_speed_merger ngsm_checker u_ngsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== dv/ngsm_merge_checker.sv =====
// transfer monitor, byte-level predictor and result comparison for the nmea gga speed merger
`timescale 1ns / 100ps

module ngsm_merge_checker #(
	parameter int VEL_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_char
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_char
	input  logic       m_axis_tlast,   // end_of_run
	input  logic       m_axis_tuser,   // [0] end_of_sentence
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [3:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         sentences_seen
);

	typedef struct packed {
		logic       sentence_end;
		logic       run_end;
		logic [7:0] ch;
	} merged_byte_t;

	localparam logic [47:0] GGA_TAG           = "$GPGGA";
	localparam logic [47:0] RMC_TAG           = "$GPRMC";
	localparam logic [71:0] NO_SPEED_TEXT     = ",NoNewVel";
	localparam logic [3:0]  SPEED_INDEX_RESET = 4'd7;
	localparam int          TOKEN_CAP         = 15;

	// predictor state
	logic [3:0]           field_idx;
	logic [7:0]           tag_buf [6];
	logic [2:0]           tag_cnt;
	ngsm_pkg::line_kind_t kind;
	logic [3:0]           tok_num;
	logic                 in_tok;
	logic [7:0]           speed_buf [VEL_MAX];
	logic [5:0]           speed_len;
	logic                 speed_fresh;

	// bytes caused by the current input transfer, then the merged byte stream still owed
	merged_byte_t burst [VEL_MAX + 10];
	int           burst_n;
	merged_byte_t merged_q [$];

	// letters, digits, newline, comma, dollar and dot pass the filter
	function automatic logic survives(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == ngsm_pkg::CH_NL ||
			c == ngsm_pkg::CH_COMMA || c == ngsm_pkg::CH_DOLLAR || c == ngsm_pkg::CH_DOT;
	endfunction

	task automatic add_out(input logic [7:0] c, input logic eos);
		burst[burst_n] = '{sentence_end: eos, run_end: 1'b0, ch: c};
		burst_n++;
	endtask

	// speed characters past the store size are lost
	task automatic keep_speed(input logic [7:0] c);
		if (speed_len < VEL_MAX) begin
			speed_buf[speed_len] = c;
			speed_len++;
		end
	endtask

	task automatic end_line();
		tag_cnt = '0;
		kind    = ngsm_pkg::KIND_UNDEC;
		tok_num = '0;
		in_tok  = 1'b0;
	endtask

	// works out the merged bytes that one received byte causes
	task automatic merge_byte(input logic [7:0] c);
		logic [47:0] tag;
		burst_n = 0;
		if (!survives(c))
			return;
		if (c == ngsm_pkg::CH_NL) begin
			// sentence end: append the fresh speed or the no-speed text
			if (kind == ngsm_pkg::KIND_GGA) begin
				if (speed_fresh) begin
					add_out(ngsm_pkg::CH_COMMA, 1'b0);
					for (int i = 0; i < speed_len; i++)
						add_out(speed_buf[i], 1'b0);
				end else begin
					for (int i = 0; i < 9; i++)
						add_out(NO_SPEED_TEXT[71 - 8 * i -: 8], 1'b0);
				end
				add_out(ngsm_pkg::CH_NL, 1'b1);
				speed_fresh = 1'b0;
			end else if (kind == ngsm_pkg::KIND_RMC) begin
				speed_fresh = 1'b1;
			end
			end_line();
		end else if (kind == ngsm_pkg::KIND_UNDEC) begin
			// collect the tag, classify on the sixth kept byte
			if (tag_cnt < 6) begin
				tag_buf[tag_cnt] = c;
				tag_cnt++;
			end
			if (tag_cnt == 6) begin
				tag = {tag_buf[0], tag_buf[1], tag_buf[2], tag_buf[3], tag_buf[4], tag_buf[5]};
				if (tag == GGA_TAG) begin
					kind = ngsm_pkg::KIND_GGA;
					for (int i = 0; i < 6; i++)
						add_out(tag_buf[i], 1'b0);
				end else if (tag == RMC_TAG) begin
					kind      = ngsm_pkg::KIND_RMC;
					speed_len = '0;
					tok_num   = '0;
					in_tok    = 1'b1;
					if (field_idx == 0)
						for (int i = 0; i < 6; i++)
							keep_speed(tag_buf[i]);
				end else begin
					kind = ngsm_pkg::KIND_OTHER;
				end
			end
		end else if (kind == ngsm_pkg::KIND_GGA) begin
			add_out(c, 1'b0);
		end else if (kind == ngsm_pkg::KIND_RMC) begin
			// non-empty token counting, empty fields are skipped
			if (c == ngsm_pkg::CH_COMMA) begin
				in_tok = 1'b0;
			end else begin
				if (!in_tok && tok_num < TOKEN_CAP) begin
					tok_num++;
					in_tok = 1'b1;
				end
				if (in_tok && tok_num == field_idx)
					keep_speed(c);
			end
		end
		for (int i = 0; i < burst_n; i++) begin
			burst[i].run_end = (i == burst_n - 1);
			merged_q.push_back(burst[i]);
		end
	endtask

	// compare one output transfer with the oldest owed byte
	task automatic check_result();
		merged_byte_t got;
		merged_byte_t want;
		got = '{sentence_end: m_axis_tuser, run_end: m_axis_tlast, ch: m_axis_tdata};
		results_seen++;
		if (got.sentence_end)
			sentences_seen++;
		if (merged_q.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected output byte: actual ch=%h last=%b eos=%b",
				$time, got.ch, got.run_end, got.sentence_end);
		end else begin
			want = merged_q.pop_front();
			if (got !== want) begin
				fail_count++;
				$display("%0t: mismatch, expected ch/last/eos %h/%b/%b actual %h/%b/%b",
					$time, want.ch, want.run_end, want.sentence_end,
					got.ch, got.run_end, got.sentence_end);
			end
		end
	endtask

	// sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_idx      = SPEED_INDEX_RESET;
			speed_len      = '0;
			speed_fresh    = 1'b0;
			end_line();
			merged_q.delete();
			burst_n        = 0;
			fail_count     = 0;
			pending        = 0;
			results_seen   = 0;
			sentences_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				merge_byte(s_axis_tdata);
			if (cfg_valid && cfg_ready)
				field_idx = cfg_data;
			pending = merged_q.size();
		end
	end

endmodule

// ===== dv/nmea_gga_speed_merger_test.sv =====
// stimulus, stall patterns and verdict for the nmea gga speed merger testbench
`timescale 1ns / 100ps

module nmea_gga_speed_merger_test;

	localparam int VEL_MAX        = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;

	typedef enum {
		GEN_RMC,
		GEN_GGA,
		GEN_OTHER,
		GEN_SHORT,
		GEN_NOISE
	} line_gen_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;    // [7:0] in_char
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;    // [7:0] out_char
	logic       m_axis_tlast;    // end_of_run
	logic       m_axis_tuser;    // [0] end_of_sentence
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int sentences_seen;

	int         tx_idle_pct;
	int         rx_idle_pct;
	logic       rx_hold_req;
	int         bytes_sent;
	int         lines_sent;
	int         seg_bytes;
	logic [7:0] line_q [$];

	nmea_gga_speed_merger #(
		.VEL_MAX(VEL_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	ngsm_merge_checker #(
		.VEL_MAX(VEL_MAX)
	) merge_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen),
		.sentences_seen(sentences_seen)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("timeout with %0d output bytes still owed", pending);
		$display("Simulation FAILED");
		$finish;
	end

	// output side: random back-pressure, or one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// field text: mostly digits, some dots, letters and dollars
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'(8'h30 + $urandom_range(9));
		else if (r < 65)
			return ngsm_pkg::CH_DOT;
		else if (r < 82)
			return 8'(8'h41 + $urandom_range(25));
		else if (r < 97)
			return 8'(8'h61 + $urandom_range(25));
		return ngsm_pkg::CH_DOLLAR;
	endfunction

	// bytes the filter throws away
	function automatic logic [7:0] junk_char();
		case ($urandom_range(3))
			0:       return 8'($urandom_range(9));
			1:       return 8'($urandom_range(35, 11));
			2:       return 8'($urandom_range(255, 128));
			default: return 8'($urandom_range(64, 58));
		endcase
	endfunction

	function automatic line_gen_t pick_line();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return GEN_RMC;
		else if (r < 70)
			return GEN_GGA;
		else if (r < 82)
			return GEN_OTHER;
		else if (r < 90)
			return GEN_SHORT;
		return GEN_NOISE;
	endfunction

	task automatic add_tag(input logic [47:0] tag);
		for (int i = 0; i < 6; i++)
			line_q.push_back(tag[47 - 8 * i -: 8]);
	endtask

	// comma separated fields with empty ones, long ones and stray junk
	task automatic add_tokens(input int ntok, input logic glue_first);
		int len;
		for (int t = 0; t < ntok; t++) begin
			if (!(t == 0 && glue_first))
				line_q.push_back(ngsm_pkg::CH_COMMA);
			if ($urandom_range(99) < 20)
				line_q.push_back(ngsm_pkg::CH_COMMA);
			len = ($urandom_range(99) < 10) ? $urandom_range(20, 15) : $urandom_range(6);
			repeat (len)
				line_q.push_back(($urandom_range(99) < 8) ? junk_char() : text_char());
		end
	endtask

	task automatic build_line(input line_gen_t gen);
		logic [47:0] tag;
		int          ntok;
		line_q.delete();
		case (gen)
			GEN_RMC: begin
				add_tag("$GPRMC");
				ntok = ($urandom_range(99) < 15) ? $urandom_range(18, 15) : $urandom_range(10);
				add_tokens(ntok, $urandom_range(99) < 15);
			end
			GEN_GGA: begin
				add_tag("$GPGGA");
				add_tokens($urandom_range(8), 1'b0);
			end
			GEN_OTHER: begin
				// unknown sentence or a tag with one character replaced at random
				if ($urandom_range(1)) begin
					tag = "$GPGSV";
				end else begin
					tag = $urandom_range(1) ? "$GPRMC" : "$GPGGA";
					tag[47 - 8 * $urandom_range(5) -: 8] = text_char();
				end
				add_tag(tag);
				add_tokens($urandom_range(5), 1'b0);
			end
			GEN_SHORT: begin
				repeat ($urandom_range(5))
					line_q.push_back(text_char());
			end
			default: begin
				repeat ($urandom_range(6, 1))
					line_q.push_back(8'($urandom_range(255)));
			end
		endcase
		line_q.push_back(ngsm_pkg::CH_NL);
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
		seg_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_byte(line_q[i]);
		lines_sent++;
	endtask

	task automatic run_lines(input int budget);
		seg_bytes = 0;
		while (seg_bytes < budget) begin
			build_line(pick_line());
			send_line();
		end
	endtask

	// stop sending and let every owed byte come out
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_speed_index(input logic [3:0] idx);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_data  <= idx;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		cfg_valid     = 1'b0;
		cfg_data      = 4'd0;
		rx_hold_req   = 1'b0;
		tx_idle_pct   = 25;
		rx_idle_pct   = 74;
		bytes_sent    = 0;
		lines_sent    = 0;
		seg_bytes     = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: byte extremes, short line, rmc with the speed field missing, gga after it
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("ab\n");
		send_text("$GPRMC,1\n");
		send_text("$GPGGA\n");
		lines_sent += 3;

		// sender idles a quarter of the time, receiver three quarters
		run_lines(25);
		write_speed_index(4'd1);
		run_lines(20);

		// roles swapped, highest index
		tx_idle_pct = 74;
		rx_idle_pct = 25;
		write_speed_index(4'd15);
		run_lines(25);

		// no idling, index zero picks up the tag token
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_speed_index(4'd0);
		run_lines(12);

		// long receiver hold-off while gga bytes keep coming
		rx_hold_req = 1'b1;
		repeat (2) begin
			build_line(GEN_GGA);
			send_line();
		end
		write_speed_index(4'($urandom_range(9, 2)));
		run_lines(20);

		quiesce();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d input bytes in %0d lines under five speed field settings",
			bytes_sent, lines_sent);
		$display("checked %0d output bytes forming %0d merged sentences",
			results_seen, sentences_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ngsm_pkg.sv
rtl/ngsm_front.sv
rtl/ngsm_queue.sv
rtl/ngsm_back.sv
rtl/nmea_gga_speed_merger.sv
rtl/ngsm_checker.sv
dv/ngsm_merge_checker.sv
dv/nmea_gga_speed_merger_test.sv
